/* src/sbpp_pkg.sv */
// ----------------------------------------------------------------------------
// sbpp_pkg
// Shared widths, codes, the CORDIC angle table and saturation helper for the
// spectrum bin post-processor.
// ----------------------------------------------------------------------------
package sbpp_pkg;

  localparam int MAX_ORDER    = 11;
  localparam int DATA_BITS    = 24;
  localparam int PHASE_BITS   = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ANGLE_W      = 30;
  localparam int PRE_SHIFT    = 24;
  localparam int X_W          = DATA_BITS + PRE_SHIFT + 3;
  localparam int Z_W          = 34;
  localparam int ANGLE_FRAC   = 32;

  localparam int SQ_W         = 2 * DATA_BITS;
  localparam int MAG_W        = DATA_BITS + 1;

  localparam int VAL_W        = 32;
  localparam int SUM_W        = VAL_W + 2;
  localparam int CNT_W        = MAX_ORDER;
  localparam int SIZE_W       = MAX_ORDER + 1;
  localparam int ORD_W        = 4;
  localparam int BIN_NUM_W    = 11;

  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_ORDER  = 1'd1;

  localparam logic [ORD_W-1:0] ORDER_MIN   = ORD_W'(1);
  localparam logic [ORD_W-1:0] ORDER_MAX   = ORD_W'(MAX_ORDER);
  localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(11);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_MAG         = 2'd0,
    MODE_PHASE       = 2'd1,
    MODE_DIFF        = 2'd2,
    MODE_UNWRAP_DIFF = 2'd3
  } mode_t;

  // Measurements handed from the front to the back.
  typedef struct packed {
    logic [PHASE_BITS-1:0] raw;
    logic [MAG_W-1:0]      mag;
  } bin_meas_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [ANGLE_W-1:0] cordic_angle(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] a;
    unique case (i)
      5'd0:    a = 30'h20000000;
      5'd1:    a = 30'h12E4051E;
      5'd2:    a = 30'h09FB385B;
      5'd3:    a = 30'h051111D4;
      5'd4:    a = 30'h028B0D43;
      5'd5:    a = 30'h0145D7E1;
      5'd6:    a = 30'h00A2F61E;
      5'd7:    a = 30'h00517C55;
      5'd8:    a = 30'h0028BE53;
      5'd9:    a = 30'h00145F2F;
      5'd10:   a = 30'h000A2F98;
      5'd11:   a = 30'h000517CC;
      5'd12:   a = 30'h00028BE6;
      5'd13:   a = 30'h000145F3;
      5'd14:   a = 30'h0000A2FA;
      5'd15:   a = 30'h0000517D;
      5'd16:   a = 30'h000028BE;
      5'd17:   a = 30'h0000145F;
      5'd18:   a = 30'h00000A30;
      5'd19:   a = 30'h00000518;
      5'd20:   a = 30'h0000028C;
      5'd21:   a = 30'h00000146;
      5'd22:   a = 30'h000000A3;
      5'd23:   a = 30'h00000051;
      5'd24:   a = 30'h00000029;
      5'd25:   a = 30'h00000014;
      5'd26:   a = 30'h0000000A;
      5'd27:   a = 30'h00000005;
      5'd28:   a = 30'h00000003;
      5'd29:   a = 30'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/sbpp_in_if.sv */
// ----------------------------------------------------------------------------
// sbpp_in_if
// Input bin channel: one complex bin per beat.
// ----------------------------------------------------------------------------
interface sbpp_in_if import sbpp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] bin_real;
  logic signed [DATA_BITS-1:0] bin_imag;

  modport source (output valid, output bin_real, output bin_imag, input ready);
  modport sink   (input valid, input bin_real, input bin_imag, output ready);
endinterface

/* src/sbpp_out_if.sv */
// ----------------------------------------------------------------------------
// sbpp_out_if
// Result channel: one value per bin per beat.
// ----------------------------------------------------------------------------
interface sbpp_out_if import sbpp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] bin_value;
  logic [BIN_NUM_W-1:0]    bin_number;
  logic                    frame_end;

  modport source (output valid, output bin_value, output bin_number, output frame_end,
                  input ready);
  modport sink   (input valid, input bin_value, input bin_number, input frame_end,
                  output ready);
endinterface

/* src/sbpp_cfg_if.sv */
// ----------------------------------------------------------------------------
// sbpp_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface sbpp_cfg_if import sbpp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/sbpp_front.sv */
// ----------------------------------------------------------------------------
// sbpp_front
// Accepts a bin, runs an iterative CORDIC for the phase and an iterative
// square root for the magnitude, and pushes both into the queue.
// ----------------------------------------------------------------------------
module sbpp_front import sbpp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sbpp_in_if.sink      in_ch,
  output logic         q_push,
  output bin_meas_t    q_data,
  input  logic         q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_PREP = 4'b0010,
    F_RUN  = 4'b0100,
    F_DONE = 4'b1000
  } front_state_t;

  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(2**30);
  localparam logic signed [Z_W-1:0] Z_ROUND   = Z_W'(2**(ANGLE_FRAC-PHASE_BITS-1));
  localparam logic [SQ_W-1:0]       BIT_START = SQ_W'(1) << (SQ_W - 2);
  localparam logic [PHASE_BITS-1:0] PHASE_NEG_PI = {1'b1, {(PHASE_BITS-1){1'b0}}};

  front_state_t                state_r, state_nxt;
  logic signed [DATA_BITS-1:0] re_r, re_nxt, im_r, im_nxt;
  logic [SQ_W-1:0]             sq_re_r, sq_re_nxt, sq_im_r, sq_im_nxt;
  logic signed [X_W-1:0]       x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]       z_r, z_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [SQ_W-1:0]             rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic                        axis_r, axis_nxt, axis_neg_r, axis_neg_nxt;

  logic signed [X_W-1:0]       xs, ys, dx, dy;
  logic signed [Z_W-1:0]       ang, zsum;
  logic [SQ_W-1:0]             trial;

  assign in_ch.ready = (state_r == F_IDLE);

  always_comb begin
    xs    = X_W'(re_r) <<< PRE_SHIFT;
    ys    = X_W'(im_r) <<< PRE_SHIFT;
    dx    = y_r >>> step_r;
    dy    = x_r >>> step_r;
    ang   = Z_W'(cordic_angle(step_r));
    trial = root_r + bit_r;
    zsum  = z_r + Z_ROUND;
  end

  always_comb begin
    state_nxt    = state_r;
    re_nxt       = re_r;
    im_nxt       = im_r;
    sq_re_nxt    = sq_re_r;
    sq_im_nxt    = sq_im_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    step_nxt     = step_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    bit_nxt      = bit_r;
    axis_nxt     = axis_r;
    axis_neg_nxt = axis_neg_r;
    q_push       = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          re_nxt    = in_ch.bin_real;
          im_nxt    = in_ch.bin_imag;
          sq_re_nxt = in_ch.bin_real * in_ch.bin_real;
          sq_im_nxt = in_ch.bin_imag * in_ch.bin_imag;
          state_nxt = F_PREP;
        end
      end
      F_PREP: begin
        // Rotate the left half plane by a quarter turn.
        if (re_r < 0) begin
          if (im_r > 0) begin
            x_nxt = ys;
            y_nxt = -xs;
            z_nxt = Z_QUARTER;
          end else begin
            x_nxt = -ys;
            y_nxt = xs;
            z_nxt = -Z_QUARTER;
          end
        end else begin
          x_nxt = xs;
          y_nxt = ys;
          z_nxt = '0;
        end
        axis_nxt     = (im_r == '0);
        axis_neg_nxt = (re_r < 0);
        rem_nxt      = sq_re_r + sq_im_r;
        root_nxt     = '0;
        bit_nxt      = BIT_START;
        step_nxt     = '0;
        state_nxt    = F_RUN;
      end
      F_RUN: begin
        if (y_r > 0) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + ang;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - ang;
        end
        if (bit_r != '0) begin
          if (rem_r >= trial) begin
            rem_nxt  = rem_r - trial;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = F_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      F_DONE: begin
        q_push = !q_full;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    if (axis_r) begin
      q_data.raw = axis_neg_r ? PHASE_NEG_PI : '0;
    end else begin
      q_data.raw = zsum[ANGLE_FRAC-1 -: PHASE_BITS];
    end
    q_data.mag = MAG_W'(root_r) + MAG_W'(rem_r > root_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    sq_re_r    <= sq_re_nxt;
    sq_im_r    <= sq_im_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    axis_r     <= axis_nxt;
    axis_neg_r <= axis_neg_nxt;
  end

endmodule

/* src/sbpp_queue.sv */
// ----------------------------------------------------------------------------
// sbpp_queue
// Two-entry queue of bin measurements between the front and the back.
// ----------------------------------------------------------------------------
module sbpp_queue import sbpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bin_meas_t push_data,
  output logic      full,
  input  logic      pop,
  output bin_meas_t pop_data,
  output logic      empty
);

  bin_meas_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/sbpp_back.sv */
// ----------------------------------------------------------------------------
// sbpp_back
// Frame counter, phase unwrap, first difference and mode select; drives the
// registered result channel.
// ----------------------------------------------------------------------------
module sbpp_back import sbpp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mode_t            mode,
  input  logic [ORD_W-1:0] size_order,
  input  bin_meas_t        q_data,
  input  logic             q_empty,
  output logic             q_pop,
  sbpp_out_if.source       out_ch
);

  localparam logic signed [PHASE_BITS:0] HALF_P = (PHASE_BITS+1)'(2**(PHASE_BITS-1));
  localparam logic signed [PHASE_BITS:0] HALF_N = -HALF_P;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [PHASE_BITS-1:0]      prev_raw_r;
  logic signed [VAL_W-1:0]    corr_sum_r, corr_sum_nxt;
  logic signed [VAL_W-1:0]    prev_diff_r, prev_diff_nxt;
  logic                       out_valid_r;
  logic signed [VAL_W-1:0]    out_value_r, value_nxt;
  logic [BIN_NUM_W-1:0]       out_num_r;
  logic                       out_end_r;

  logic [ORD_W-1:0]           ord;
  logic [SIZE_W-1:0]          size, half_size;
  logic [CNT_W-1:0]           pos;
  logic                       last, in_half;
  logic signed [PHASE_BITS-1:0] raw;
  logic signed [PHASE_BITS:0] dp, dps;
  logic signed [PHASE_BITS+1:0] corr;
  logic signed [SUM_W-1:0]    sum_wide, uw_wide;
  logic signed [VAL_W-1:0]    uw_sat;

  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_value  = out_value_r;
  assign out_ch.bin_number = out_num_r;
  assign out_ch.frame_end  = out_end_r;

  // Frame position.
  always_comb begin
    if (size_order < ORDER_MIN) begin
      ord = ORDER_MIN;
    end else if (size_order > ORDER_MAX) begin
      ord = ORDER_MAX;
    end else begin
      ord = size_order;
    end
    size      = SIZE_W'(1) << ord;
    half_size = size >> 1;
    pos       = (SIZE_W'(cnt_r) >= size) ? '0 : cnt_r;
    last      = (SIZE_W'(pos) == size - SIZE_W'(1));
    cnt_nxt   = last ? '0 : pos + CNT_W'(1);
    in_half   = (pos != '0) && (SIZE_W'(pos) < half_size);
  end

  // Unwrap: wrap the jump, accumulate the correction when it reaches pi within the first half of the frame.
  always_comb begin
    raw = q_data.raw;
    dp  = (PHASE_BITS+1)'(raw) - (PHASE_BITS+1)'(signed'(prev_raw_r));
    dps = (PHASE_BITS+1)'(signed'(dp[PHASE_BITS-1:0]));
    if ((dps == HALF_N) && (dp > 0)) begin
      dps = HALF_P;
    end
    corr     = (PHASE_BITS+2)'(dps) - (PHASE_BITS+2)'(dp);
    sum_wide = SUM_W'(corr_sum_r) + SUM_W'(corr);
    if (pos == '0) begin
      corr_sum_nxt = '0;
    end else if (in_half && ((dp >= HALF_P) || (dp <= HALF_N))) begin
      corr_sum_nxt = sat_val(sum_wide);
    end else begin
      corr_sum_nxt = corr_sum_r;
    end
    uw_wide = SUM_W'(raw) + (in_half ? SUM_W'(corr_sum_nxt) : SUM_W'(0));
    uw_sat  = sat_val(uw_wide);
  end

  // Mode select; the difference memory moves only in the difference modes.
  always_comb begin
    prev_diff_nxt = prev_diff_r;
    unique case (mode)
      MODE_MAG: begin
        value_nxt = VAL_W'(q_data.mag);
      end
      MODE_PHASE: begin
        value_nxt = VAL_W'(raw);
      end
      MODE_DIFF: begin
        value_nxt     = sat_val(SUM_W'(raw) - SUM_W'(prev_diff_r));
        prev_diff_nxt = VAL_W'(raw);
      end
      MODE_UNWRAP_DIFF: begin
        value_nxt     = sat_val(SUM_W'(uw_sat) - SUM_W'(prev_diff_r));
        prev_diff_nxt = uw_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      prev_raw_r  <= '0;
      corr_sum_r  <= '0;
      prev_diff_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cnt_r       <= cnt_nxt;
        prev_raw_r  <= q_data.raw;
        corr_sum_r  <= corr_sum_nxt;
        prev_diff_r <= prev_diff_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_value_r <= value_nxt;
      out_num_r   <= BIN_NUM_W'(pos);
      out_end_r   <= last;
    end
  end

endmodule

/* src/spectrum_bin_post_processor.sv */
// ----------------------------------------------------------------------------
// spectrum_bin_post_processor
// Per-bin magnitude, phase, phase difference or unwrapped phase difference
// of complex spectrum bins, selected by the output mode register.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat carries                         handshake
//   -------  ---  -----------------------------------  -----------
//   in_ch    in   bin_real, bin_imag (24b signed)      valid/ready
//   out_ch   out  bin_value (32b), bin_number, frame_end valid/ready
//   cfg_ch   in   index (0 mode, 1 order), data (4b)   valid/ready
//
// A bin passes the front in order: one state to latch and square the inputs,
// one to pre-rotate, 30 CORDIC iterations (the square root runs alongside
// on the same step counter), one to hand off; the front takes no new bin
// until it is back in idle. The back registers each result.
// Synchronous active-low reset clears counters, unwrap state and the
// difference memory and sets mode 0, order 11. A stalled result channel
// fills the two-entry queue, then holds the front in its hand-off state.
// cfg_ch is always ready.
//
module spectrum_bin_post_processor import sbpp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sbpp_in_if.sink      in_ch,
  sbpp_out_if.source   out_ch,
  sbpp_cfg_if.sink     cfg_ch
);

  mode_t            mode_r, mode_nxt;
  logic [ORD_W-1:0] order_r, order_nxt;

  logic      q_push, q_full, q_pop, q_empty;
  bin_meas_t q_wdata, q_rdata;

  // Take every configuration beat at once.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    order_nxt = order_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_OUTPUT_MODE: mode_nxt  = mode_t'(cfg_ch.data[1:0]);
        REG_SIZE_ORDER:  order_nxt = cfg_ch.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MAG;
      order_r <= ORDER_RESET;
    end else begin
      mode_r  <= mode_nxt;
      order_r <= order_nxt;
    end
  end

  // Front: phase and magnitude of each accepted bin.
  sbpp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // Decouple the iterative front from a stalled result channel.
  sbpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back: frame position, unwrap, difference and mode select.
  sbpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .size_order (order_r),
    .q_data     (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule
